// ----- hw/rtl/serial_setpoint_step_pulse_generator_core_assert.svh -----
// Assertion macros shared by the serial setpoint step-pulse generator RTL.
// Each macro expects clk_i in scope; SSPG_ASSERT also expects rst_ni.
`ifndef SERIAL_SETPOINT_STEP_PULSE_GENERATOR_CORE_ASSERT_SVH
`define SERIAL_SETPOINT_STEP_PULSE_GENERATOR_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SSPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/sspg_pkg.sv -----
// ----------------------------------------------------------------------------
// sspg_pkg
// Shared types and constants of the serial setpoint step-pulse generator.
// ----------------------------------------------------------------------------
package sspg_pkg;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_DEADBAND  = 2'd0;
  localparam logic [1:0] REG_DIR_THRES = 2'd1;
  localparam logic [1:0] REG_PULSE_LIM = 2'd2;

  // Configuration reset values
  localparam logic [15:0] DEADBAND_RST  = 16'd10;
  localparam logic [15:0] DIR_THRES_RST = 16'd140;
  localparam logic [15:0] PULSE_LIM_RST = 16'd3000;

  // Default queue depths
  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned RES_QUEUE_DEPTH = 2;

  // Command kinds produced by the front end
  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic signed [31:0] setpoint;
  } cmd_t;

  typedef struct packed {
    logic               step_level;
    logic               direction;
    logic               running;
    logic               new_sample;
    logic signed [31:0] setpoint;
  } res_t;

endpackage

// ----- hw/rtl/serial_setpoint_step_pulse_generator_core.sv -----
// ----------------------------------------------------------------------------
// serial_setpoint_step_pulse_generator_core
// Serial float setpoint receiver driving a step-pulse run generator.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock (a serial byte or a timer tick) while the
// command queue is not full, and returns exactly one result for each, in order.
// A transaction is classified and converted combinationally by the front end,
// registered in the command queue, executed by the back end when the result
// queue has room, and registered in the result queue, which drives the result
// ports. Throughput is one transaction per cycle while the queues do not stall;
// stalls on pop propagate to full only once both queues have filled.
// Configuration registers: 0 deadband, 1 direction threshold, 2 pulse limit.
module serial_setpoint_step_pulse_generator_core #(
  parameter int unsigned CmdDepth = sspg_pkg::CMD_QUEUE_DEPTH,
  parameter int unsigned ResDepth = sspg_pkg::RES_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic               opcode_i,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               step_level_o,
  output logic               direction_o,
  output logic               running_o,
  output logic               new_sample_o,
  output logic signed [31:0] setpoint_o
);

  import sspg_pkg::*;

  logic accept;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_empty;
  logic res_full;
  logic back_fire;
  res_t back_res;
  res_t out_res;

  assign accept    = push && !full;
  assign back_fire = !cmd_empty && !res_full;

  // Classify and convert incoming transactions
  sspg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .opcode_i  (opcode_i),
    .rx_byte_i (rx_byte_i),
    .cmd_o     (front_cmd)
  );

  // Decouple front and back
  sspg_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_en_i   (back_fire),
    .rd_data_o (back_cmd),
    .empty_o   (cmd_empty)
  );

  // Execute commands
  sspg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (back_fire),
    .cmd_i       (back_cmd),
    .res_o       (back_res)
  );

  // Hold results until popped
  sspg_fifo #(
    .Width ($bits(res_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (back_fire),
    .wr_data_i (back_res),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (out_res),
    .empty_o   (empty)
  );

  assign step_level_o = out_res.step_level;
  assign direction_o  = out_res.direction;
  assign running_o    = out_res.running;
  assign new_sample_o = out_res.new_sample;
  assign setpoint_o   = out_res.setpoint;

endmodule

// ----- hw/rtl/sspg_fifo.sv -----
// ----------------------------------------------------------------------------
// sspg_fifo
// Small first-in first-out queue with push/pop handshakes on both sides.
// ----------------------------------------------------------------------------
module sspg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_fire, rd_fire;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign wr_fire   = wr_en_i && !full_o;
  assign rd_fire   = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_fire && !rd_fire) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_fire && !wr_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store incoming transaction
  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`include "serial_setpoint_step_pulse_generator_core_assert.svh"

  `SSPG_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue occupancy exceeds depth")
  `SSPG_ASSERT(a_wr_not_empty, (wr_fire && !rd_fire) |=> !empty_o, "write lost in queue")
  `SSPG_ASSERT(a_ptr_gap,
               (cnt_q != '0 && cnt_q != CntW'(Depth)) |-> (wr_ptr_q != rd_ptr_q),
               "pointers collide while partly filled")

endmodule

// ----- hw/rtl/sspg_front.sv -----
// ----------------------------------------------------------------------------
// sspg_front
// Collects serial bytes into single floats, converts them to integer
// setpoints and classifies each transaction into a command.
// ----------------------------------------------------------------------------
module sspg_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               opcode_i,
  input  logic [7:0]         rx_byte_i,
  output sspg_pkg::cmd_t     cmd_o
);

  import sspg_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic [23:0] store_q, store_d;

  // Truncate an IEEE single toward zero with saturation; NaN gives zero
  function automatic logic [31:0] float_to_int(input logic [31:0] bits);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [31:0] base;
    logic [31:0] mag;
    logic [7:0]  lsh;
    logic [7:0]  rsh;
    sgn  = bits[31];
    ex   = bits[30:23];
    man  = bits[22:0];
    base = {8'd0, 1'b1, man};
    lsh  = ex - 8'd150;
    rsh  = 8'd150 - ex;
    if (ex == 8'd255 && man != '0) begin
      float_to_int = '0;
    end else if (ex >= 8'd158) begin
      float_to_int = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (ex < 8'd127) begin
      float_to_int = '0;
    end else begin
      if (ex >= 8'd150) begin
        mag = base << lsh[2:0];
      end else begin
        mag = base >> rsh[4:0];
      end
      float_to_int = sgn ? (32'd0 - mag) : mag;
    end
  endfunction

  // Classify the transaction and assemble bytes
  always_comb begin
    idx_d          = idx_q;
    store_d        = store_q;
    cmd_o.kind     = CMD_TICK;
    cmd_o.setpoint = '0;
    if (opcode_i == OP_BYTE) begin
      if (idx_q != 2'd3) begin
        cmd_o.kind = CMD_BYTE;
        store_d    = store_q | ({16'd0, rx_byte_i} << {idx_q, 3'b000});
        idx_d      = idx_q + 2'd1;
      end else begin
        cmd_o.kind     = CMD_SAMPLE;
        cmd_o.setpoint = float_to_int({rx_byte_i, store_q});
        store_d        = '0;
        idx_d          = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      store_q <= '0;
    end else if (accept_i) begin
      idx_q   <= idx_d;
      store_q <= store_d;
    end
  end

`include "serial_setpoint_step_pulse_generator_core_assert.svh"

  `SSPG_ASSERT(a_idx_wrap, (accept_i && opcode_i == OP_BYTE && idx_q == 2'd3) |=> (idx_q == 2'd0 && store_q == '0), "byte assembly not restarted after a float")
  `SSPG_ASSERT(a_tick_hold, (accept_i && opcode_i == OP_TICK) |=> ($stable(idx_q) && $stable(store_q)), "tick disturbed byte assembly")
  `SSPG_ASSERT(a_idle_hold, !accept_i |=> $stable(idx_q), "byte index moved without a transaction")

endmodule

// ----- hw/rtl/sspg_back.sv -----
// ----------------------------------------------------------------------------
// sspg_back
// Executes commands: deadband test, run start, step toggling and counting,
// and builds one result per command. Holds the configuration registers.
// ----------------------------------------------------------------------------
module sspg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               fire_i,
  input  sspg_pkg::cmd_t     cmd_i,
  output sspg_pkg::res_t     res_o
);

  import sspg_pkg::*;

  logic [15:0]        deadband_q;
  logic [15:0]        thres_q;
  logic [15:0]        limit_q;

  logic signed [31:0] cur_q, cur_d;
  logic signed [31:0] last_q, last_d;
  logic [15:0]        tick_q, tick_d;
  logic               run_q, run_d;
  logic               phase_q, phase_d;
  logic               step_q, step_d;
  logic               dir_q, dir_d;

  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [15:0]        tick_inc;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
      thres_q    <= DIR_THRES_RST;
      limit_q    <= PULSE_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DEADBAND:  deadband_q <= cfg_wdata_i;
        REG_DIR_THRES: thres_q    <= cfg_wdata_i;
        REG_PULSE_LIM: limit_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign diff     = {cmd_i.setpoint[31], cmd_i.setpoint} - {last_q[31], last_q};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign tick_inc = tick_q + 16'd1;

  // Apply one command to the run state
  always_comb begin
    cur_d   = cur_q;
    last_d  = last_q;
    tick_d  = tick_q;
    run_d   = run_q;
    phase_d = phase_q;
    step_d  = step_q;
    dir_d   = dir_q;
    case (cmd_i.kind)
      CMD_SAMPLE: begin
        cur_d = cmd_i.setpoint;
        if (diff_mag > {17'd0, deadband_q}) begin
          tick_d = '0;
          run_d  = 1'b1;
          last_d = cmd_i.setpoint;
          if (cmd_i.setpoint < $signed({{16{thres_q[15]}}, thres_q})) begin
            dir_d = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (run_q) begin
          step_d  = phase_q;
          phase_d = ~phase_q;
          tick_d  = tick_inc;
          if (tick_inc >= limit_q) begin
            tick_d = '0;
            run_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      last_q  <= '0;
      tick_q  <= '0;
      run_q   <= 1'b0;
      phase_q <= 1'b0;
      step_q  <= 1'b0;
      dir_q   <= 1'b0;
    end else if (fire_i) begin
      cur_q   <= cur_d;
      last_q  <= last_d;
      tick_q  <= tick_d;
      run_q   <= run_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      dir_q   <= dir_d;
    end
  end

  // Result reflects the state after this command
  always_comb begin
    res_o.step_level = step_d;
    res_o.direction  = dir_d;
    res_o.running    = run_d;
    res_o.new_sample = (cmd_i.kind == CMD_SAMPLE);
    res_o.setpoint   = cur_d;
  end

`include "serial_setpoint_step_pulse_generator_core_assert.svh"

  `SSPG_ASSERT(a_dir_sticky, dir_q |=> dir_q, "direction latch cleared")
  `SSPG_ASSERT_ALWAYS(a_idle_count, !run_q |-> (tick_q == '0), "tick count nonzero while idle")
  `SSPG_ASSERT(a_idle_tick, (fire_i && cmd_i.kind == CMD_TICK && !run_q) |=> ($stable(step_q) && $stable(phase_q)), "idle tick moved the step output")

endmodule

// ----- dv/serial_setpoint_step_pulse_generator_core_tb.sv -----
// ----------------------------------------------------------------------------
// serial_setpoint_step_pulse_generator_core_tb
// Self-checking testbench for the serial setpoint step-pulse generator core.
// ----------------------------------------------------------------------------
// Pushes serial bytes and timer ticks into the core and predicts every result
// with a behavioral model of the float-to-setpoint conversion, the deadband
// test, the sticky direction latch and the step-pulse run counter. Each popped
// result is compared field by field with the oldest prediction. A directed
// part covers saturation, NaN, run restart and a zero pulse limit; random
// traffic then runs under several register settings and idle/stall profiles.
// ----------------------------------------------------------------------------
module serial_setpoint_step_pulse_generator_core_tb;
  import sspg_pkg::*;

  // Index outside the register map; writes to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         MAX_REPORTS = 100;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_addr_i  = REG_DEADBAND;
  logic [15:0]        cfg_wdata_i = '0;
  logic               push        = 1'b0;
  logic               full;
  logic               opcode_i    = OP_BYTE;
  logic [7:0]         rx_byte_i   = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic               step_level_o;
  logic               direction_o;
  logic               running_o;
  logic               new_sample_o;
  logic signed [31:0] setpoint_o;

  // Model copy of the registers and the core state
  logic [15:0]        deadband_q;
  logic signed [15:0] dir_threshold_q;
  logic [15:0]        pulse_limit_q;
  logic [1:0]         byte_pos;
  logic [23:0]        low_bytes;
  logic signed [31:0] cur_setpoint;
  logic signed [31:0] prev_setpoint;
  logic [15:0]        tick_cnt;
  logic               run_active;
  logic               half_phase;
  logic               step_pin;
  logic               dir_latch;

  res_t expected_pulse_q[$];
  res_t exp_res;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int fail_count    = 0;
  int n_items       = 0;
  int n_ticks       = 0;
  int n_results     = 0;
  int n_samples     = 0;
  int n_run_starts  = 0;
  int n_settings    = 0;

  serial_setpoint_step_pulse_generator_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .empty        (empty),
    .pop          (pop),
    .step_level_o (step_level_o),
    .direction_o  (direction_o),
    .running_o    (running_o),
    .new_sample_o (new_sample_o),
    .setpoint_o   (setpoint_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Truncate a single-precision float toward zero, saturating and mapping NaN to 0
  function automatic logic signed [31:0] float_bits_to_setpoint(input logic [31:0] bits);
    logic [7:0]  ex;
    logic [63:0] mag;
    ex  = bits[30:23];
    mag = {40'd0, 1'b1, bits[22:0]};
    if (ex == 8'hFF && bits[22:0] != 23'd0) return '0;
    if (ex >= 8'd158) return bits[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    if (ex < 8'd127) return '0;
    if (ex >= 8'd150) mag = mag << (ex - 8'd150);
    else mag = mag >> (8'd150 - ex);
    return bits[31] ? -mag[31:0] : mag[31:0];
  endfunction

  // Advance the model by one accepted transaction and queue the expected outputs
  function automatic void advance_pulse_model(input logic op, input logic [7:0] b);
    logic [31:0] word;
    longint      gap;
    res_t        r;
    r.new_sample = 1'b0;
    if (op == OP_BYTE) begin
      if (byte_pos != 2'd3) begin
        low_bytes = low_bytes | (24'(b) << (8 * byte_pos));
        byte_pos  = byte_pos + 2'd1;
      end else begin
        word         = {b, low_bytes};
        byte_pos     = '0;
        low_bytes    = '0;
        r.new_sample = 1'b1;
        cur_setpoint = float_bits_to_setpoint(word);
        gap = longint'(cur_setpoint) - longint'(prev_setpoint);
        if (gap < 0) gap = -gap;
        // Start (or restart) the run when the change exceeds the deadband
        if (gap > longint'(deadband_q)) begin
          tick_cnt = '0;
          if (cur_setpoint < dir_threshold_q) dir_latch = 1'b1;
          run_active    = 1'b1;
          prev_setpoint = cur_setpoint;
          n_run_starts++;
        end
      end
    end else if (run_active) begin
      // Toggle the pin: low on the first half, high on the second
      step_pin   = half_phase;
      half_phase = ~half_phase;
      tick_cnt   = tick_cnt + 16'd1;
      if (tick_cnt >= pulse_limit_q) begin
        tick_cnt   = '0;
        run_active = 1'b0;
      end
    end
    r.step_level = step_pin;
    r.direction  = dir_latch;
    r.running    = run_active;
    r.setpoint   = cur_setpoint;
    expected_pulse_q.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (fail_count < MAX_REPORTS)
        $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Check each popped result and pick the next pop level
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_pulse_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $error("result with no transaction pending: setpoint %0h", setpoint_o);
        fail_count++;
      end else begin
        exp_res = expected_pulse_q.pop_front();
        check_field("step_level", exp_res.step_level, step_level_o);
        check_field("direction", exp_res.direction, direction_o);
        check_field("running", exp_res.running, running_o);
        check_field("new_sample", exp_res.new_sample, new_sample_o);
        check_field("setpoint", exp_res.setpoint, setpoint_o);
        n_results++;
        if (new_sample_o) n_samples++;
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Push one transaction, idling at random first, and hold until accepted
  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push      <= 1'b0;
      opcode_i  <= 1'($urandom);
      rx_byte_i <= 8'($urandom);
      @(posedge clk_i);
    end
    push      <= 1'b1;
    opcode_i  <= op;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    advance_pulse_model(op, b);
    n_items++;
    if (op == OP_TICK) n_ticks++;
  endtask

  task automatic send_float(input logic [31:0] bits);
    for (int k = 0; k < 4; k++) send_item(OP_BYTE, bits[8*k +: 8]);
  endtask

  // Send a float biased toward the interesting exponents, with ticks mixed in
  task automatic send_random_float();
    logic [31:0] bits;
    logic [7:0]  ex;
    int          sel;
    sel = $urandom_range(99);
    if (sel < 70) ex = 8'($urandom_range(160, 126));
    else if (sel < 80) ex = 8'd0;
    else if (sel < 88) ex = 8'hFF;
    else ex = 8'($urandom_range(255));
    bits = {1'($urandom), ex, ($urandom_range(3) == 0) ? 23'd0 : 23'($urandom)};
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(3) == 0) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, bits[8*k +: 8]);
    end
  endtask

  // Drop push and wait until every expected result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_pulse_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_DEADBAND:  deadband_q      = val;
      REG_DIR_THRES: dir_threshold_q = val;
      REG_PULSE_LIM: pulse_limit_q   = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] db, input logic [15:0] thr,
                           input logic [15:0] lim);
    wait_drained();
    write_reg(REG_DEADBAND, db);
    write_reg(REG_DIR_THRES, thr);
    write_reg(REG_PULSE_LIM, lim);
    write_reg(REG_UNUSED, 16'($urandom));
    n_settings++;
  endtask

  // A tick with no run active only reports the state
  task automatic test_idle_tick();
    send_item(OP_TICK, 8'h00);
  endtask

  // Saturate both ways, NaN to zero, restart while running, set the latch
  task automatic test_float_conversion();
    send_float(32'h7F80_0000);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h5A);
    send_float(32'h4EFF_FFFF);
    send_float(32'h7FC0_0000);
    send_float(32'hFF80_0000);
  endtask

  // With a zero pulse limit the run ends on its first tick
  task automatic test_zero_pulse_limit();
    configure(DEADBAND_RST, DIR_THRES_RST, 16'd0);
    send_float(32'h0000_0001);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
  endtask

  // Mostly well-formed floats, plus tick bursts and stray bytes
  task automatic test_random_traffic(input logic [15:0] db, input logic [15:0] thr,
                                     input logic [15:0] lim, input int idle_pct,
                                     input int stall_pct, input int n);
    int stop_at;
    int sel;
    int cnt;
    configure(db, thr, lim);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        send_random_float();
      end else if (sel < 90) begin
        cnt = $urandom_range(8, 1);
        repeat (cnt) send_item(OP_TICK, 8'($urandom));
      end else begin
        cnt = $urandom_range(3, 1);
        repeat (cnt) send_item(OP_BYTE, 8'($urandom));
      end
    end
  endtask

  initial begin
    deadband_q      = DEADBAND_RST;
    dir_threshold_q = DIR_THRES_RST;
    pulse_limit_q   = PULSE_LIM_RST;
    byte_pos        = '0;
    low_bytes       = '0;
    cur_setpoint    = '0;
    prev_setpoint   = '0;
    tick_cnt        = '0;
    run_active      = 1'b0;
    half_phase      = 1'b0;
    step_pin        = 1'b0;
    dir_latch       = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_tick();
    test_float_conversion();
    test_zero_pulse_limit();
    test_random_traffic(16'd0, 16'h8000, 16'd1, 0, 0, 260);
    test_random_traffic(16'hFFFF, 16'h7FFF, 16'hFFFF, 88, 0, 260);
    test_random_traffic(16'($urandom), 16'($urandom), 16'($urandom_range(40, 1)),
                        0, 88, 260);
    test_random_traffic(16'($urandom_range(300)), 16'($urandom_range(600) - 300),
                        16'($urandom_range(64, 2)), 14, 14, 260);
    wait_drained();

    $display("Checked %0d results for %0d transactions (%0d ticks, %0d float samples).",
             n_results, n_items, n_ticks, n_samples);
    $display("Saw %0d predicted run starts across %0d register settings.",
             n_run_starts, n_settings);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/sspg_pkg.sv
hw/rtl/sspg_fifo.sv
hw/rtl/sspg_front.sv
hw/rtl/sspg_back.sv
hw/rtl/serial_setpoint_step_pulse_generator_core.sv
dv/serial_setpoint_step_pulse_generator_core_tb.sv
